// ----- src/rsw_pkg.sv -----
package rsw_pkg;

   localparam int TAG_W            = 7;
   localparam int DATA_W           = 32;
   localparam int STATION_W        = 4;
   localparam int COUNT_W          = 7;
   localparam int MASK_W           = 16;
   localparam int OPNDS            = 4;
   localparam int DEFAULT_STATIONS = 16;

   // operand slots inside one station
   localparam int OPND_INT_A = 0;
   localparam int OPND_INT_B = 1;
   localparam int OPND_FP_A  = 2;
   localparam int OPND_FP_B  = 3;

   localparam logic [TAG_W-1:0] TAG_PRESENT = '1;

   typedef enum logic {
      FUNC_DISPATCH  = 1'b0,
      FUNC_BROADCAST = 1'b1
   } func_type;

   // first member lands in the highest bits
   typedef struct packed {
      logic        [DATA_W-1:0]    fp_value_b;
      logic signed [TAG_W-1:0]     fp_tag_b;
      logic        [DATA_W-1:0]    fp_value_a;
      logic signed [TAG_W-1:0]     fp_tag_a;
      logic signed [DATA_W-1:0]    int_value_b;
      logic signed [TAG_W-1:0]     int_tag_b;
      logic signed [DATA_W-1:0]    int_value_a;
      logic signed [TAG_W-1:0]     int_tag_a;
      logic                        thread;
      logic        [STATION_W-1:0] station;
   } rsw_item_type;

   localparam int ITEM_W = $bits(rsw_item_type);

   typedef struct packed {
      logic load;    // write this station from the word
      logic wake;    // bus broadcast active
      logic free;    // this station is the producer
      logic thread;  // producer's thread
   } rsw_ctrl_type;

   typedef struct packed {
      logic             busy;    // busy after this word
      logic             ready;   // busy with all tags clear after this word
      logic             thread;  // stored owner
      logic [OPNDS-1:0] hits;    // operands captured by this word
   } rsw_status_type;

endpackage

// ----- src/rsw_station.sv -----
module rsw_station
   import rsw_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  rsw_ctrl_type   ctrl,
   input  rsw_item_type   item,
   output rsw_status_type status
);

   logic              busy_ff, busy_in;
   logic              thread_ff, thread_in;
   logic [TAG_W-1:0]  tag_ff   [OPNDS];
   logic [TAG_W-1:0]  tag_in   [OPNDS];
   logic [DATA_W-1:0] value_ff [OPNDS];
   logic [DATA_W-1:0] value_in [OPNDS];
   logic [TAG_W-1:0]  bus_tag  [OPNDS];
   logic [DATA_W-1:0] bus_val  [OPNDS];
   logic [OPNDS-1:0]  hit;
   logic              wake_match;
   logic              all_clear;

   always_comb begin
      bus_tag[OPND_INT_A] = item.int_tag_a;
      bus_tag[OPND_INT_B] = item.int_tag_a;
      bus_tag[OPND_FP_A]  = item.fp_tag_a;
      bus_tag[OPND_FP_B]  = item.fp_tag_a;
      bus_val[OPND_INT_A] = item.int_value_a;
      bus_val[OPND_INT_B] = item.int_value_a;
      bus_val[OPND_FP_A]  = item.fp_value_a;
      bus_val[OPND_FP_B]  = item.fp_value_a;

      wake_match = ctrl.wake && busy_ff && (thread_ff == ctrl.thread);

      for (int i = 0; i < OPNDS; i++) begin
         // a negative stored tag is present and never matches
         hit[i]      = wake_match && !tag_ff[i][TAG_W-1] && (tag_ff[i] == bus_tag[i]);
         tag_in[i]   = hit[i] ? TAG_PRESENT : tag_ff[i];
         value_in[i] = hit[i] ? bus_val[i]  : value_ff[i];
      end
      thread_in = thread_ff;
      busy_in   = ctrl.free ? 1'b0 : busy_ff;

      if (ctrl.load) begin
         busy_in              = 1'b1;
         thread_in            = item.thread;
         tag_in[OPND_INT_A]   = item.int_tag_a;
         tag_in[OPND_INT_B]   = item.int_tag_b;
         tag_in[OPND_FP_A]    = item.fp_tag_a;
         tag_in[OPND_FP_B]    = item.fp_tag_b;
         value_in[OPND_INT_A] = item.int_value_a;
         value_in[OPND_INT_B] = item.int_value_b;
         value_in[OPND_FP_A]  = item.fp_value_a;
         value_in[OPND_FP_B]  = item.fp_value_b;
      end

      all_clear = 1'b1;
      for (int i = 0; i < OPNDS; i++) begin
         all_clear = all_clear && tag_in[i][TAG_W-1];
      end

      status.busy   = busy_in;
      status.ready  = busy_in && all_clear;
      status.thread = thread_ff;
      status.hits   = hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      thread_ff <= thread_in;
      tag_ff    <= tag_in;
      value_ff  <= value_in;
   end

endmodule

// ----- src/reservation_station_wakeup.sv -----
// Pool of STATIONS reservation stations woken by a common data bus. A word
// with tuser 0 dispatches an instruction into one station: its thread, two
// integer and two float source tags with values (a tag of -1, or any negative
// tag, means the value is already present). A word with tuser 1 is a result
// broadcast: every busy station of the producer's thread whose waiting tag
// equals the integer or float bus tag captures the value, then the producer
// station is freed. A station index at or above STATIONS changes nothing.
// Each word answers with one result word: ready and busy masks after the
// update (stations 0 to 15) and the number of operands captured. The block
// takes one word per cycle while results are drained; each word is held in
// the input register, then one pass of the tag compare across all stations
// in parallel lands in the result register. Both registers advance together,
// so while a result waits to be drained the input register still takes one
// more word; with both full, req_tready drops until the result is taken.
module reservation_station_wakeup
   import rsw_pkg::*;
#(
   parameter int STATIONS = DEFAULT_STATIONS
)
(
   input  logic         clock,
   input  logic         reset,
   // req_tdata, lowest bit up: station, thread, int_tag_a, int_value_a,
   // int_tag_b, int_value_b, fp_tag_a, fp_value_a, fp_tag_b, fp_value_b, zeros
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [167:0] req_tdata,
   // req_tuser: func
   input  logic [0:0]   req_tuser,
   // rsp_tdata, lowest bit up: ready_mask, busy_mask, capture_count, zeros
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata
);

   localparam int HIT_W = OPNDS * STATIONS;

   // input register
   logic         in_valid_ff, in_valid_in;
   func_type     in_func_ff;
   rsw_item_type in_item_ff;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0]  ready_mask_ff, ready_mask_in;
   logic [MASK_W-1:0]  busy_mask_ff, busy_mask_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic           advance;
   logic           in_range;
   logic           producer_thread;
   logic [HIT_W-1:0] hit_vec;
   rsw_ctrl_type   ctrl   [STATIONS];
   rsw_status_type status [STATIONS];

   // move a word out of the input register whenever the result slot frees up
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign in_range   = 32'(in_item_ff.station) < STATIONS;

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_func_ff <= func_type'(req_tuser[0]);
         in_item_ff <= rsw_item_type'(req_tdata[ITEM_W-1:0]);
      end
      if (advance) begin
         ready_mask_ff <= ready_mask_in;
         busy_mask_ff  <= busy_mask_in;
         count_ff      <= count_in;
      end
   end

   // read the producer's stored thread
   always_comb begin
      producer_thread = 1'b0;
      for (int s = 0; s < STATIONS; s++) begin
         if (32'(in_item_ff.station) == s) begin
            producer_thread = status[s].thread;
         end
      end
   end

   for (genvar s = 0; s < STATIONS; s++) begin : g_station
      always_comb begin
         ctrl[s].load   = advance && (in_func_ff == FUNC_DISPATCH) && in_range &&
                          (32'(in_item_ff.station) == s);
         ctrl[s].wake   = advance && (in_func_ff == FUNC_BROADCAST) && in_range;
         ctrl[s].free   = ctrl[s].wake && (32'(in_item_ff.station) == s);
         ctrl[s].thread = producer_thread;
      end

      rsw_station u_station (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (ctrl[s]),
         .item   (in_item_ff),
         .status (status[s])
      );

      assign hit_vec[s*OPNDS +: OPNDS] = status[s].hits;
   end

   // only the first sixteen stations show in the masks
   for (genvar m = 0; m < MASK_W; m++) begin : g_mask
      if (m < STATIONS) begin : g_live
         assign ready_mask_in[m] = status[m].ready;
         assign busy_mask_in[m]  = status[m].busy;
      end else begin : g_none
         assign ready_mask_in[m] = 1'b0;
         assign busy_mask_in[m]  = 1'b0;
      end
   end

   // count wraps to the field width
   assign count_in = COUNT_W'($countones(hit_vec));

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, count_ff, busy_mask_ff, ready_mask_ff};

`ifndef SYNTH
   a_ready_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((ready_mask_ff & ~busy_mask_ff) == '0))
      else $error("ready station not busy");

   a_dispatch_busy: assert property (@(posedge clock) disable iff (reset)
      (advance && (in_func_ff == FUNC_DISPATCH) && in_range &&
       (32'(in_item_ff.station) < MASK_W))
      |=> busy_mask_ff[$past(in_item_ff.station)])
      else $error("dispatched station not busy");

   a_dispatch_no_capture: assert property (@(posedge clock) disable iff (reset)
      (advance && (in_func_ff == FUNC_DISPATCH)) |=> (count_ff == '0))
      else $error("capture on dispatch");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("input stalled without a blocked result");
`endif

endmodule

// ----- dv/reservation_station_wakeup_tb.sv -----
module reservation_station_wakeup_tb
   import rsw_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int                 QUIET_LIMIT   = 5000;  // cycles with no handshake at all
   localparam int                 SETTLE_CYCLES = 8;     // two-stage pipe plus margin
   localparam int                 HOLD_CYCLES   = 300;   // long receiver hold-off
   localparam int                 PHASE_WORDS   = 400;
   localparam logic [TAG_W-1:0]   TAG_NEG_LOW   = 7'h40; // -64, present like -1
   localparam logic [TAG_W-1:0]   TAG_NEG_TWO   = 7'h7E; // -2

   // rsp_tdata fields; first member lands in the highest bits
   typedef struct packed {
      logic [COUNT_W-1:0] capture_count;
      logic [MASK_W-1:0]  busy_mask;
      logic [MASK_W-1:0]  ready_mask;
   } wake_result_type;

   typedef struct {
      func_type        func;
      rsw_item_type    item;
      bit              typed;   // use the hand-written result below
      wake_result_type want;
   } dispatch_row_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [167:0] req_tdata  = '0;
   logic [0:0]   req_tuser  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [39:0]  rsp_tdata;

   reservation_station_wakeup i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // shadow copy of the station pool
   logic                  rs_busy   [DEFAULT_STATIONS];
   logic                  rs_loaded [DEFAULT_STATIONS];  // dispatched at least once
   logic                  rs_thread [DEFAULT_STATIONS];
   logic signed [TAG_W-1:0] rs_tag  [DEFAULT_STATIONS][OPNDS];
   logic [DATA_W-1:0]     rs_value  [DEFAULT_STATIONS][OPNDS];

   wake_result_type  pending_results[$];
   dispatch_row_type dispatch_table[$];
   logic [TAG_W-1:0] tag_pool[3];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_left      = 0;
   int quiet_cycles   = 0;
   int errors         = 0;

   wake_result_type got_word, want_word;

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(string msg);
      errors++;
      $display("ERROR at %0t: %s", $time, msg);
   endtask

   // Apply one word to the shadow pool and return the result it must produce.
   function automatic wake_result_type predict_wakeup(func_type f, rsw_item_type it);
      wake_result_type         r;
      logic                    prod_thread;
      logic signed [TAG_W-1:0] bus_tag;
      logic [DATA_W-1:0]       bus_value;
      int                      hits;
      int                      s;
      int                      o;
      hits = 0;
      r    = '0;
      if (f == FUNC_DISPATCH) begin
         rs_busy[it.station]               = 1'b1;
         rs_loaded[it.station]             = 1'b1;
         rs_thread[it.station]             = it.thread;
         rs_tag[it.station][OPND_INT_A]    = it.int_tag_a;
         rs_tag[it.station][OPND_INT_B]    = it.int_tag_b;
         rs_tag[it.station][OPND_FP_A]     = it.fp_tag_a;
         rs_tag[it.station][OPND_FP_B]     = it.fp_tag_b;
         rs_value[it.station][OPND_INT_A]  = it.int_value_a;
         rs_value[it.station][OPND_INT_B]  = it.int_value_b;
         rs_value[it.station][OPND_FP_A]   = it.fp_value_a;
         rs_value[it.station][OPND_FP_B]   = it.fp_value_b;
      end else begin
         prod_thread = rs_thread[it.station];
         for (s = 0; s < DEFAULT_STATIONS; s++) begin
            if (rs_busy[s] && rs_thread[s] == prod_thread) begin
               for (o = 0; o < OPNDS; o++) begin
                  bus_tag   = (o == OPND_INT_A || o == OPND_INT_B) ? it.int_tag_a : it.fp_tag_a;
                  bus_value = (o == OPND_INT_A || o == OPND_INT_B) ?
                              it.int_value_a : it.fp_value_a;
                  // a negative stored tag is already present and never matches
                  if (!rs_tag[s][o][TAG_W-1] && rs_tag[s][o] == bus_tag) begin
                     rs_value[s][o] = bus_value;
                     rs_tag[s][o]   = TAG_PRESENT;
                     hits++;
                  end
               end
            end
         end
         rs_busy[it.station] = 1'b0;
      end
      for (s = 0; s < DEFAULT_STATIONS && s < MASK_W; s++) begin
         if (rs_busy[s]) begin
            r.busy_mask[s]  = 1'b1;
            r.ready_mask[s] = rs_tag[s][OPND_INT_A][TAG_W-1] && rs_tag[s][OPND_INT_B][TAG_W-1] &&
                              rs_tag[s][OPND_FP_A][TAG_W-1]  && rs_tag[s][OPND_FP_B][TAG_W-1];
         end
      end
      r.capture_count = hits[COUNT_W-1:0];
      return r;
   endfunction

   function automatic dispatch_row_type mk_row(func_type f, int st, bit thr,
                                            logic [TAG_W-1:0] ita, logic [DATA_W-1:0] iva,
                                            logic [TAG_W-1:0] itb, logic [DATA_W-1:0] ivb,
                                            logic [TAG_W-1:0] fta, logic [DATA_W-1:0] fva,
                                            logic [TAG_W-1:0] ftb, logic [DATA_W-1:0] fvb,
                                            bit typed, logic [MASK_W-1:0] rdy,
                                            logic [MASK_W-1:0] bsy, int cnt);
      dispatch_row_type r;
      r.func             = f;
      r.item             = '0;
      r.item.station     = st[STATION_W-1:0];
      r.item.thread      = thr;
      r.item.int_tag_a   = ita;
      r.item.int_value_a = iva;
      r.item.int_tag_b   = itb;
      r.item.int_value_b = ivb;
      r.item.fp_tag_a    = fta;
      r.item.fp_value_a  = fva;
      r.item.fp_tag_b    = ftb;
      r.item.fp_value_b  = fvb;
      r.typed            = typed;
      r.want.ready_mask  = rdy;
      r.want.busy_mask   = bsy;
      r.want.capture_count = cnt[COUNT_W-1:0];
      return r;
   endfunction

   // Offer one word, hold it until taken, then record what it must produce.
   // tvalid is left high; the caller drops it when no word follows at once.
   task automatic send_word(func_type f, rsw_item_type it, bit typed, wake_result_type want);
      wake_result_type pred;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {7'b0, it};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = predict_wakeup(f, it);
      pending_results.push_back(typed ? want : pred);
   endtask

   // Mostly tags from a small pool so that broadcasts hit; the rest present or arbitrary.
   function automatic logic [TAG_W-1:0] pick_tag();
      int r;
      r = $urandom_range(9);
      if (r < 2)
         return TAG_PRESENT;
      else if (r == 2)
         return TAG_NEG_LOW | TAG_W'($urandom_range(63));
      else if (r == 3)
         return TAG_W'($urandom());
      return tag_pool[$urandom_range(2)];
   endfunction

   task automatic reroll_pool();
      int k;
      for (k = 0; k < 3; k++) tag_pool[k] = TAG_W'($urandom_range(63));
   endtask

   task automatic send_random();
      rsw_item_type it;
      func_type     f;
      it             = '0;
      it.station     = STATION_W'($urandom_range(15));
      it.thread      = 1'($urandom_range(1));
      it.int_tag_a   = pick_tag();
      it.int_value_a = $urandom();
      it.int_tag_b   = pick_tag();
      it.int_value_b = $urandom();
      it.fp_tag_a    = pick_tag();
      it.fp_value_a  = $urandom();
      it.fp_tag_b    = pick_tag();
      it.fp_value_b  = $urandom();
      f = $urandom_range(1) ? FUNC_BROADCAST : FUNC_DISPATCH;
      // never name a producer whose owner was never written
      if (f == FUNC_BROADCAST && !rs_loaded[it.station]) f = FUNC_DISPATCH;
      send_word(f, it, 1'b0, '0);
   endtask

   // Fill every station of one thread with the same waiting tags, then broadcast
   // them all at once: the largest capture count.
   task automatic send_fill();
      rsw_item_type     it;
      logic             thr;
      logic [TAG_W-1:0] itag;
      logic [TAG_W-1:0] ftag;
      int               s;
      thr  = 1'($urandom_range(1));
      itag = TAG_W'($urandom_range(63));
      ftag = TAG_W'($urandom_range(63));
      for (s = 0; s < DEFAULT_STATIONS; s++) begin
         it             = '0;
         it.station     = STATION_W'(s);
         it.thread      = thr;
         it.int_tag_a   = itag;
         it.int_value_a = $urandom();
         it.int_tag_b   = itag;
         it.int_value_b = $urandom();
         it.fp_tag_a    = ftag;
         it.fp_value_a  = $urandom();
         it.fp_tag_b    = ftag;
         it.fp_value_b  = $urandom();
         send_word(FUNC_DISPATCH, it, 1'b0, '0);
      end
      it.station     = STATION_W'($urandom_range(15));
      it.thread      = 1'($urandom_range(1));
      it.int_value_a = $urandom();
      it.fp_value_a  = $urandom();
      send_word(FUNC_BROADCAST, it, 1'b0, '0);
   endtask

   // Receiver: stall at random, or hold off completely while a hold-off is counting.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Check each result word against the oldest expectation; watch for a hang.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result word %h with nothing expected", rsp_tdata));
         end else begin
            want_word = pending_results.pop_front();
            got_word  = rsp_tdata[$bits(wake_result_type)-1:0];
            if (got_word.ready_mask !== want_word.ready_mask)
               report_mismatch($sformatf("ready_mask %h, expected %h",
                                         got_word.ready_mask, want_word.ready_mask));
            if (got_word.busy_mask !== want_word.busy_mask)
               report_mismatch($sformatf("busy_mask %h, expected %h",
                                         got_word.busy_mask, want_word.busy_mask));
            if (got_word.capture_count !== want_word.capture_count)
               report_mismatch($sformatf("capture_count %0d, expected %0d",
                                         got_word.capture_count, want_word.capture_count));
         end
      end
   end

   initial begin
      int s;
      int p;
      int i;
      for (s = 0; s < DEFAULT_STATIONS; s++) begin
         rs_busy[s]   = 1'b0;
         rs_loaded[s] = 1'b0;
         rs_thread[s] = 1'b0;
      end
      reroll_pool();

      // Directed words. Masks and counts follow by hand from the order of the rows.
      // plain dispatch, all operands present, extreme values
      dispatch_table.push_back(mk_row(FUNC_DISPATCH, 0, 0, TAG_PRESENT, 32'h7FFF_FFFF,
         TAG_PRESENT, 32'h8000_0000, TAG_PRESENT, 32'h0, TAG_PRESENT, 32'hFFFF_FFFF,
         1, 16'h0001, 16'h8001 & 16'h0001, 0));
      // highest station, highest tag everywhere
      dispatch_table.push_back(mk_row(FUNC_DISPATCH, 15, 1, 7'd63, 32'h8000_0000,
         7'd63, 32'h7FFF_FFFF, 7'd63, 32'hFFFF_FFFF, 7'd63, 32'h0,
         1, 16'h0001, 16'h8001, 0));
      // producer wakes all four of its own operands before it is freed
      dispatch_table.push_back(mk_row(FUNC_BROADCAST, 15, 1, 7'd63, 32'h1234_5678,
         TAG_PRESENT, 32'h0, 7'd63, 32'hCAFE_F00D, TAG_PRESENT, 32'h0,
         1, 16'h0001, 16'h0001, 4));
      // broadcast from an idle producer: stored thread, nothing to free
      dispatch_table.push_back(mk_row(FUNC_BROADCAST, 15, 0, 7'd63, 32'h0,
         7'd0, 32'h0, 7'd63, 32'h0, 7'd0, 32'h0, 1, 16'h0001, 16'h0001, 0));
      // other negative tags count as present
      dispatch_table.push_back(mk_row(FUNC_DISPATCH, 3, 0, TAG_NEG_LOW, 32'h1,
         TAG_NEG_TWO, 32'h2, 7'd5, 32'h3, 7'd5, 32'h4, 1, 16'h0001, 16'h0009, 0));
      dispatch_table.push_back(mk_row(FUNC_DISPATCH, 4, 1, 7'd5, 32'h5,
         7'd5, 32'h6, 7'd5, 32'h7, 7'd5, 32'h8, 1, 16'h0001, 16'h0019, 0));
      // negative integer bus tag matches nothing; float tag wakes only thread 0
      dispatch_table.push_back(mk_row(FUNC_BROADCAST, 0, 1, TAG_PRESENT, 32'h9,
         7'd0, 32'h0, 7'd5, 32'hA, 7'd0, 32'h0, 1, 16'h0008, 16'h0018, 2));
      dispatch_table.push_back(mk_row(FUNC_BROADCAST, 0, 0, 7'd5, 32'hB,
         7'd0, 32'h0, TAG_PRESENT, 32'hC, 7'd0, 32'h0, 1, 16'h0008, 16'h0018, 0));
      // dispatch into a busy station overwrites it
      dispatch_table.push_back(mk_row(FUNC_DISPATCH, 3, 1, 7'd7, 32'hD,
         TAG_PRESENT, 32'hE, TAG_PRESENT, 32'hF, TAG_PRESENT, 32'h10,
         1, 16'h0000, 16'h0018, 0));
      dispatch_table.push_back(mk_row(FUNC_BROADCAST, 4, 0, 7'd5, 32'h11,
         7'd0, 32'h0, 7'd7, 32'h12, 7'd0, 32'h0, 1, 16'h0000, 16'h0008, 2));
      dispatch_table.push_back(mk_row(FUNC_BROADCAST, 3, 0, 7'd7, 32'h13,
         7'd0, 32'h0, 7'd0, 32'h14, 7'd0, 32'h0, 1, 16'h0000, 16'h0000, 1));
      // tag zero on two stations of one thread
      dispatch_table.push_back(mk_row(FUNC_DISPATCH, 8, 0, 7'd0, 32'h15,
         7'd0, 32'h16, 7'd0, 32'h17, 7'd0, 32'h18, 1, 16'h0000, 16'h0100, 0));
      dispatch_table.push_back(mk_row(FUNC_DISPATCH, 9, 0, 7'd0, 32'h19,
         7'd0, 32'h1A, 7'd0, 32'h1B, 7'd0, 32'h1C, 1, 16'h0000, 16'h0300, 0));
      dispatch_table.push_back(mk_row(FUNC_BROADCAST, 8, 1, 7'd0, 32'hFFFF_FFFF,
         7'd0, 32'h0, 7'd0, 32'h8000_0000, 7'd0, 32'h0, 1, 16'h0200, 16'h0300 & 16'h0200, 8));
      // crossed tags: integer and float buses stay apart
      dispatch_table.push_back(mk_row(FUNC_DISPATCH, 1, 1, 7'd63, 32'h1D,
         TAG_PRESENT, 32'h1E, 7'd62, 32'h1F, TAG_PRESENT, 32'h20, 0, '0, '0, 0));
      dispatch_table.push_back(mk_row(FUNC_BROADCAST, 1, 0, 7'd62, 32'h21,
         7'd0, 32'h0, 7'd63, 32'h22, 7'd0, 32'h0, 0, '0, '0, 0));
      dispatch_table.push_back(mk_row(FUNC_BROADCAST, 9, 1, 7'd0, 32'h23,
         7'd0, 32'h0, 7'd0, 32'h24, 7'd0, 32'h0, 0, '0, '0, 0));
      // negative bus tag against a stored negative tag: no capture
      dispatch_table.push_back(mk_row(FUNC_DISPATCH, 5, 0, TAG_NEG_LOW, 32'h25,
         TAG_NEG_LOW, 32'h26, TAG_NEG_LOW, 32'h27, TAG_NEG_LOW, 32'h28,
         1, 16'h0020, 16'h0020, 0));
      dispatch_table.push_back(mk_row(FUNC_BROADCAST, 5, 0, TAG_NEG_LOW, 32'h29,
         7'd0, 32'h0, TAG_NEG_LOW, 32'h2A, 7'd0, 32'h0, 1, 16'h0000, 16'h0000, 0));

      // hold reset, then release it
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dispatch_table[i])
         send_word(dispatch_table[i].func, dispatch_table[i].item,
                   dispatch_table[i].typed, dispatch_table[i].want);

      // Random words in four idling phases: none, sender only, receiver only, both.
      for (p = 0; p < 4; p++) begin
         send_idle_pct  = (p == 1) ? 54 : (p == 3) ? 17 : 0;
         recv_stall_pct = (p == 2) ? 54 : (p == 3) ? 17 : 0;
         for (i = 0; i < PHASE_WORDS; i++) begin
            if (i % 40 == 0) reroll_pool();
            if (i % 150 == 75) send_fill();
            // hold the receiver off while words keep coming, so the pipe fills
            if (p == 0 && i == 200) hold_left = HOLD_CYCLES;
            // pause the sender until every result has drained
            if (p == 2 && i == 230) begin
               req_tvalid <= 1'b0;
               while (pending_results.size() != 0) @(posedge clock);
            end
            send_random();
         end
      end
      req_tvalid <= 1'b0;

      // drain, then let the pipe settle
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
src/rsw_pkg.sv
src/rsw_station.sv
src/reservation_station_wakeup.sv
dv/reservation_station_wakeup_tb.sv
